FILE: rtl/power_mode_vote_arbiter_core_macros.svh
// Assertion helpers for the power mode vote arbiter.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef POWER_MODE_VOTE_ARBITER_CORE_MACROS_SVH
`define POWER_MODE_VOTE_ARBITER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PVMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PVMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pvma_pkg.sv
// ----------------------------------------------------------------------------
// Power mode vote arbiter package
// Sizes, operation codes, status codes and register indexes of the arbiter.
// ----------------------------------------------------------------------------
package pvma_pkg;

   localparam int SLEEP_MODES = 8;
   localparam int RUN_MODES   = 8;
   localparam int VOTE_BITS   = 8;
   localparam int IDLE_LEVEL  = 1;
   localparam int LOCK_LEVEL  = 0;

   localparam int MODE_W   = 3;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int TICKS_W  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int SLEEP_IDX_W = (SLEEP_MODES > 1) ? $clog2(SLEEP_MODES) : 1;
   localparam int RUN_IDX_W   = (RUN_MODES > 1) ? $clog2(RUN_MODES) : 1;

   typedef logic [VOTE_BITS-1:0] vote_count_type;
   typedef logic [MODE_W-1:0]    mode_type;

   typedef enum logic [OP_W-1:0] {
      OP_SLEEP_REQUEST = 3'd0,
      OP_SLEEP_RELEASE = 3'd1,
      OP_RUN_REQUEST   = 3'd2,
      OP_RUN_RELEASE   = 3'd3,
      OP_IDLE_ENTRY    = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLEEP_DEFAULT   = 2'd0,
      CSR_RUN_DEFAULT     = 2'd1,
      CSR_SLEEP_THRESHOLD = 2'd2
   } csr_index_type;

endpackage

FILE: rtl/power_mode_vote_arbiter_core.sv
// A request is captured in the input register, resolved combinationally into the
// result register and strobed from there.
// Throughput: one request per cycle; busy never rises and the result is
// strobed for one cycle, since the receiver cannot stall.
// Synchronous reset clears all vote counters, the current run mode,
// the configuration registers and the pipeline valid bits.
// ----------------------------------------------------------------------------
// Power mode vote arbiter core
// Counts sleep and run mode votes, resolves the sleep and run modes and
// picks the level for idle entry.
// ----------------------------------------------------------------------------
`include "power_mode_vote_arbiter_core_macros.svh"

module power_mode_vote_arbiter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [pvma_pkg::OP_W-1:0]        req_op,
   input  logic [pvma_pkg::MODE_W-1:0]      req_mode,
   input  logic [pvma_pkg::TICKS_W-1:0]     req_planned_ticks,
   output logic                             rsp_strobe,
   output logic [pvma_pkg::STATUS_W-1:0]    rsp_status,
   output logic [pvma_pkg::MODE_W-1:0]      rsp_sleep_mode,
   output logic [pvma_pkg::MODE_W-1:0]      rsp_run_mode,
   output logic                             rsp_run_changed,
   output logic                             rsp_deep_sleep,
   input  logic                             csr_write_enable,
   input  logic [pvma_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pvma_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import pvma_pkg::*;

   // Configuration registers.
   mode_type            sleep_default_ff;
   mode_type            run_default_ff;
   logic [TICKS_W-1:0]  sleep_threshold_ff;

   // Input register.
   logic                req_valid_ff;
   logic [OP_W-1:0]     req_op_ff;
   mode_type            req_mode_ff;
   logic [TICKS_W-1:0]  req_ticks_ff;

   // Arbiter state.
   vote_count_type      sleep_votes_ff [SLEEP_MODES];
   vote_count_type      run_votes_ff   [RUN_MODES];
   vote_count_type      sleep_votes_in [SLEEP_MODES];
   vote_count_type      run_votes_in   [RUN_MODES];
   mode_type            current_run_ff;
   mode_type            current_run_in;

   // Result register.
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   status_type          rsp_status_in;
   mode_type            rsp_sleep_mode_ff;
   mode_type            rsp_sleep_mode_in;
   mode_type            rsp_run_mode_ff;
   logic                rsp_run_changed_ff;
   logic                rsp_deep_sleep_ff;
   logic                rsp_deep_sleep_in;

   // Decode helpers.
   logic                sleep_in_range;
   logic                run_in_range;
   logic [SLEEP_IDX_W-1:0] sleep_idx;
   logic [RUN_IDX_W-1:0]   run_idx;
   mode_type            resolved_sleep;
   mode_type            resolved_run;
   logic                force_idle;

   // The core never holds requests off.
   assign busy = 1'b0;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         sleep_default_ff   <= '0;
         run_default_ff     <= '0;
         sleep_threshold_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SLEEP_DEFAULT:   sleep_default_ff   <= csr_write_data[MODE_W-1:0];
            CSR_RUN_DEFAULT:     run_default_ff     <= csr_write_data[MODE_W-1:0];
            CSR_SLEEP_THRESHOLD: sleep_threshold_ff <= csr_write_data[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the request.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         req_op_ff    <= req_op;
         req_mode_ff  <= req_mode;
         req_ticks_ff <= req_planned_ticks;
      end
   end

   assign sleep_in_range = (32'(req_mode_ff) < SLEEP_MODES);
   assign run_in_range   = (32'(req_mode_ff) < RUN_MODES);
   assign sleep_idx      = SLEEP_IDX_W'(req_mode_ff);
   assign run_idx        = RUN_IDX_W'(req_mode_ff);

   // Vote counter update; full and empty counters are left alone.
   always_comb begin
      rsp_status_in = STATUS_OK;
      for (int i = 0; i < SLEEP_MODES; i++) begin
         sleep_votes_in[i] = sleep_votes_ff[i];
      end
      for (int i = 0; i < RUN_MODES; i++) begin
         run_votes_in[i] = run_votes_ff[i];
      end
      case (op_type'(req_op_ff))
         OP_SLEEP_REQUEST: begin
            if (sleep_in_range) begin
               if (sleep_votes_ff[sleep_idx] != '1) begin
                  sleep_votes_in[sleep_idx] = sleep_votes_ff[sleep_idx] + VOTE_BITS'(1);
               end else begin
                  rsp_status_in = STATUS_FULL;
               end
            end
         end
         OP_SLEEP_RELEASE: begin
            if (sleep_in_range) begin
               if (sleep_votes_ff[sleep_idx] != '0) begin
                  sleep_votes_in[sleep_idx] = sleep_votes_ff[sleep_idx] - VOTE_BITS'(1);
               end else begin
                  rsp_status_in = STATUS_EMPTY;
               end
            end
         end
         OP_RUN_REQUEST: begin
            if (run_in_range) begin
               if (run_votes_ff[run_idx] != '1) begin
                  run_votes_in[run_idx] = run_votes_ff[run_idx] + VOTE_BITS'(1);
               end else begin
                  rsp_status_in = STATUS_FULL;
               end
            end
         end
         OP_RUN_RELEASE: begin
            if (run_in_range) begin
               if (run_votes_ff[run_idx] != '0) begin
                  run_votes_in[run_idx] = run_votes_ff[run_idx] - VOTE_BITS'(1);
               end else begin
                  rsp_status_in = STATUS_EMPTY;
               end
            end
         end
         default: ;
      endcase
   end

   // Lowest voted sleep mode below the default, scanned from the top so
   // that the lowest one wins.
   always_comb begin
      resolved_sleep = sleep_default_ff;
      for (int i = SLEEP_MODES - 1; i >= 0; i--) begin
         if ((i < int'(sleep_default_ff)) && (sleep_votes_in[i] != '0)) begin
            resolved_sleep = MODE_W'(i);
         end
      end
   end

   // Highest voted run mode above the default.
   always_comb begin
      resolved_run = run_default_ff;
      for (int i = 0; i < RUN_MODES; i++) begin
         if ((i > int'(run_default_ff)) && (run_votes_in[i] != '0)) begin
            resolved_run = MODE_W'(i);
         end
      end
   end

   // Sleep level choice and run mode switch.
   assign force_idle = (32'(resolved_sleep) <= IDLE_LEVEL) ||
                       (req_ticks_ff <= sleep_threshold_ff);

   always_comb begin
      current_run_in    = current_run_ff;
      rsp_sleep_mode_in = resolved_sleep;
      rsp_deep_sleep_in = 1'b0;
      case (op_type'(req_op_ff))
         OP_RUN_REQUEST: begin
            if ((resolved_run != current_run_ff) && (32'(resolved_run) != LOCK_LEVEL)) begin
               current_run_in = resolved_run;
            end
         end
         OP_IDLE_ENTRY: begin
            current_run_in    = resolved_run;
            rsp_deep_sleep_in = ~force_idle;
            if (force_idle) begin
               rsp_sleep_mode_in = MODE_W'(IDLE_LEVEL);
            end
         end
         default: ;
      endcase
   end

   // State update.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLEEP_MODES; i++) begin
            sleep_votes_ff[i] <= '0;
         end
         for (int i = 0; i < RUN_MODES; i++) begin
            run_votes_ff[i] <= '0;
         end
         current_run_ff <= '0;
      end else if (req_valid_ff) begin
         for (int i = 0; i < SLEEP_MODES; i++) begin
            sleep_votes_ff[i] <= sleep_votes_in[i];
         end
         for (int i = 0; i < RUN_MODES; i++) begin
            run_votes_ff[i] <= run_votes_in[i];
         end
         current_run_ff <= current_run_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_status_ff      <= rsp_status_in;
         rsp_sleep_mode_ff  <= rsp_sleep_mode_in;
         rsp_run_mode_ff    <= current_run_in;
         rsp_run_changed_ff <= (current_run_in != current_run_ff);
         rsp_deep_sleep_ff  <= rsp_deep_sleep_in;
      end
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_sleep_mode  = rsp_sleep_mode_ff;
   assign rsp_run_mode    = rsp_run_mode_ff;
   assign rsp_run_changed = rsp_run_changed_ff;
   assign rsp_deep_sleep  = rsp_deep_sleep_ff;

   // Checks.
   `PVMA_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_valid_ff, rsp_valid_ff, "request lost")
   `PVMA_ASSERT_NEXT(a_run_holds_idle, clock, reset, !req_valid_ff, $stable(current_run_ff), "run mode moved without a request")
   `PVMA_ASSERT_SAME(a_deep_is_idle, clock, reset, rsp_valid_ff && rsp_deep_sleep_ff, (rsp_status_ff == STATUS_OK) && (32'(rsp_sleep_mode_ff) > IDLE_LEVEL), "deep sleep flag inconsistent")

endmodule

FILE: verif/power_mode_vote_arbiter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Power mode vote arbiter core testbench
// Drives vote, release and idle entry requests into the arbiter, predicts each
// result with a behavioral copy of the vote counters and the mode resolution,
// and compares every strobed result field by field. The configuration is
// changed between phases while the block is idle. The run covers three sender
// gap profiles and ends with a burst that drives one vote counter into
// saturation.
// ----------------------------------------------------------------------------
module power_mode_vote_arbiter_core_test;
   import pvma_pkg::*;

   localparam int CLOCK_PERIOD     = 12;
   localparam int RESET_CYCLES     = 10;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int PHASE_ITEMS      = 50;
   localparam int SATURATION_EXTRA = 3;
   localparam int PRINT_LIMIT      = 40;

   localparam logic [OP_W-1:0]      OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0]      OP_SPARE_LAST  = 3'd7;
   localparam vote_count_type       VOTE_FULL      = '1;
   localparam logic [TICKS_W-1:0]   TICKS_MAX      = '1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      mode_type           mode;
      logic [TICKS_W-1:0] ticks;
   } vote_item_type;

   typedef struct packed {
      status_type status;
      mode_type   sleep_mode;
      mode_type   run_mode;
      logic       run_changed;
      logic       deep_sleep;
   } arbiter_outcome_type;

   // Block ports; the inputs are known from time zero.
   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    start             = 1'b0;
   logic                    busy;
   logic [OP_W-1:0]         req_op            = '0;
   mode_type                req_mode          = '0;
   logic [TICKS_W-1:0]      req_planned_ticks = '0;
   logic                    rsp_strobe;
   logic [STATUS_W-1:0]     rsp_status;
   mode_type                rsp_sleep_mode;
   mode_type                rsp_run_mode;
   logic                    rsp_run_changed;
   logic                    rsp_deep_sleep;
   logic                    csr_write_enable  = 1'b0;
   csr_index_type           csr_index         = CSR_SLEEP_DEFAULT;
   logic [CSR_DATA_W-1:0]   csr_write_data    = '0;

   // Expected arbiter state and configuration.
   vote_count_type          sleep_tally [SLEEP_MODES] = '{default: '0};
   vote_count_type          run_tally   [RUN_MODES]   = '{default: '0};
   mode_type                run_now           = '0;
   mode_type                cfg_sleep_default = '0;
   mode_type                cfg_run_default   = '0;
   logic [TICKS_W-1:0]      cfg_threshold     = '0;

   // Request backlog, outstanding predictions and run statistics.
   vote_item_type           vote_backlog [$];
   arbiter_outcome_type     awaited_outcomes [$];
   vote_item_type           presented;
   int                      sender_gap_pct = 19;
   int                      error_count    = 0;
   int                      accepted_count = 0;
   int                      checked_count  = 0;
   int                      full_seen      = 0;
   int                      empty_seen     = 0;
   int                      deep_seen      = 0;
   int                      switch_seen    = 0;
   int                      cycle_count    = 0;

   power_mode_vote_arbiter_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_mode          (req_mode),
      .req_planned_ticks (req_planned_ticks),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_sleep_mode    (rsp_sleep_mode),
      .rsp_run_mode      (rsp_run_mode),
      .rsp_run_changed   (rsp_run_changed),
      .rsp_deep_sleep    (rsp_deep_sleep),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Lightest voted sleep mode below the default, else the default.
   function automatic mode_type resolve_sleep_level();
      for (int i = 0; i < SLEEP_MODES; i++) begin
         if (i < cfg_sleep_default && sleep_tally[i] != '0) begin
            return mode_type'(i);
         end
      end
      return cfg_sleep_default;
   endfunction

   // Highest voted run mode above the default, else the default.
   function automatic mode_type resolve_run_level();
      for (int m = RUN_MODES - 1; m > int'(cfg_run_default); m--) begin
         if (run_tally[m] != '0) begin
            return mode_type'(m);
         end
      end
      return cfg_run_default;
   endfunction

   // Applies one request to the expected state and returns its result.
   function automatic arbiter_outcome_type arbitrate_vote(vote_item_type item);
      arbiter_outcome_type result;
      mode_type         prior_run;
      mode_type         run_pick;
      mode_type         sleep_pick;
      result    = '0;
      result.status = STATUS_OK;
      prior_run = run_now;
      case (item.op)
         OP_SLEEP_REQUEST: begin
            if (sleep_tally[item.mode] == VOTE_FULL) result.status = STATUS_FULL;
            else sleep_tally[item.mode]++;
         end
         OP_SLEEP_RELEASE: begin
            if (sleep_tally[item.mode] == '0) result.status = STATUS_EMPTY;
            else sleep_tally[item.mode]--;
         end
         OP_RUN_REQUEST: begin
            if (run_tally[item.mode] == VOTE_FULL) result.status = STATUS_FULL;
            else run_tally[item.mode]++;
            // The switch happens even when the vote itself was refused.
            run_pick = resolve_run_level();
            if (run_pick != run_now && run_pick != mode_type'(LOCK_LEVEL)) begin
               run_now = run_pick;
            end
         end
         OP_RUN_RELEASE: begin
            if (run_tally[item.mode] == '0) result.status = STATUS_EMPTY;
            else run_tally[item.mode]--;
         end
         default: begin
         end
      endcase
      sleep_pick = resolve_sleep_level();
      if (item.op == OP_IDLE_ENTRY) begin
         if (sleep_pick <= mode_type'(IDLE_LEVEL) || item.ticks <= cfg_threshold) begin
            sleep_pick = mode_type'(IDLE_LEVEL);
         end
         result.deep_sleep = (sleep_pick > mode_type'(IDLE_LEVEL));
         // Idle entry adopts the resolved run mode, lock mode included.
         run_now = resolve_run_level();
      end
      result.sleep_mode  = sleep_pick;
      result.run_mode    = run_now;
      result.run_changed = (run_now != prior_run);
      return result;
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("[%0t] result %0d: %s", $realtime, checked_count, what);
      end
   endtask

   // Driver: predicts each accepted request and presents the next one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_outcomes.push_back(arbitrate_vote(presented));
            accepted_count++;
         end
         if (!(start && busy)) begin
            if (vote_backlog.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
               presented         = vote_backlog.pop_front();
               start             <= 1'b1;
               req_op            <= presented.op;
               req_mode          <= presented.mode;
               req_planned_ticks <= presented.ticks;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      arbiter_outcome_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("result strobed with no request outstanding");
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_sleep_mode !== want.sleep_mode)
               report_mismatch($sformatf("sleep_mode %0d, expected %0d",
                                         rsp_sleep_mode, want.sleep_mode));
            if (rsp_run_mode !== want.run_mode)
               report_mismatch($sformatf("run_mode %0d, expected %0d",
                                         rsp_run_mode, want.run_mode));
            if (rsp_run_changed !== want.run_changed)
               report_mismatch($sformatf("run_changed %0b, expected %0b",
                                         rsp_run_changed, want.run_changed));
            if (rsp_deep_sleep !== want.deep_sleep)
               report_mismatch($sformatf("deep_sleep %0b, expected %0b",
                                         rsp_deep_sleep, want.deep_sleep));
            if (want.status == STATUS_FULL) full_seen++;
            if (want.status == STATUS_EMPTY) empty_seen++;
            if (want.deep_sleep) deep_seen++;
            if (want.run_changed) switch_seen++;
            checked_count++;
         end
      end
   end

   // Watchdog against a hung handshake or a missing result.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("power_mode_vote_arbiter_core_test: done, errors");
         $finish;
      end
   end

   task automatic push_item(logic [OP_W-1:0] op, mode_type mode, logic [TICKS_W-1:0] ticks);
      vote_item_type item;
      item.op    = op;
      item.mode  = mode;
      item.ticks = ticks;
      vote_backlog.push_back(item);
   endtask

   // Checks mid-cycle, when the driver and monitor have settled, that every
   // request has been accepted and answered, then returns at a clock edge.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (vote_backlog.size() != 0 || start || awaited_outcomes.size() != 0);
      @(posedge clock);
   endtask

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_SLEEP_DEFAULT:   cfg_sleep_default = data[MODE_W-1:0];
         CSR_RUN_DEFAULT:     cfg_run_default   = data[MODE_W-1:0];
         CSR_SLEEP_THRESHOLD: cfg_threshold     = data;
         default: begin
         end
      endcase
   endtask

   // Waits for idle, then writes all registers; mode registers carry junk high bits.
   task automatic configure(mode_type sleep_def, mode_type run_def,
                            logic [TICKS_W-1:0] threshold);
      logic [CSR_DATA_W-1:0] word;
      wait_for_drain();
      word = $urandom();
      word[MODE_W-1:0] = sleep_def;
      write_reg(CSR_SLEEP_DEFAULT, word);
      word = $urandom();
      word[MODE_W-1:0] = run_def;
      write_reg(CSR_RUN_DEFAULT, word);
      write_reg(CSR_SLEEP_THRESHOLD, threshold);
      csr_write_enable <= 1'b0;
   endtask

   // Planned ticks cluster on the extremes and around the threshold.
   function automatic logic [TICKS_W-1:0] pick_ticks();
      case ($urandom_range(4))
         0:       return '0;
         1:       return TICKS_MAX;
         2:       return cfg_threshold;
         3:       return cfg_threshold + 1'b1;
         default: return $urandom();
      endcase
   endfunction

   task automatic push_random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 22)      push_item(OP_SLEEP_REQUEST, mode_type'($urandom), pick_ticks());
      else if (pick < 42) push_item(OP_SLEEP_RELEASE, mode_type'($urandom), pick_ticks());
      else if (pick < 60) push_item(OP_RUN_REQUEST, mode_type'($urandom), pick_ticks());
      else if (pick < 76) push_item(OP_RUN_RELEASE, mode_type'($urandom), pick_ticks());
      else if (pick < 96) push_item(OP_IDLE_ENTRY, mode_type'($urandom), pick_ticks());
      else push_item(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), mode_type'($urandom),
                     pick_ticks());
   endtask

   // Random traffic with a pause halfway until every result has come back.
   task automatic random_phase(int count);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) wait_for_drain();
         push_random_item();
      end
   endtask

   // Drives one counter past full with some unrelated traffic mixed in.
   task automatic saturation_phase();
      logic     on_sleep;
      mode_type target;
      int       pick;
      on_sleep = 1'($urandom_range(1));
      target   = mode_type'($urandom);
      for (int n = 0; n < int'(VOTE_FULL) + SATURATION_EXTRA; n++) begin
         push_item(on_sleep ? OP_SLEEP_REQUEST : OP_RUN_REQUEST, target, pick_ticks());
         if ($urandom_range(4) == 0) begin
            pick = $urandom_range(2);
            if (pick == 0) push_item(OP_IDLE_ENTRY, mode_type'($urandom), pick_ticks());
            else if (on_sleep)
               push_item(pick == 1 ? OP_RUN_REQUEST : OP_RUN_RELEASE, mode_type'($urandom),
                         pick_ticks());
            else
               push_item(pick == 1 ? OP_SLEEP_REQUEST : OP_SLEEP_RELEASE, mode_type'($urandom),
                         pick_ticks());
         end
      end
      push_item(on_sleep ? OP_SLEEP_RELEASE : OP_RUN_RELEASE, target, pick_ticks());
      push_item(on_sleep ? OP_SLEEP_RELEASE : OP_RUN_RELEASE, target, pick_ticks());
   endtask

   // Stimulus sequence.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: empty counters and an unused operation code.
      push_item(OP_SLEEP_RELEASE, 3'd0, '0);
      push_item(OP_RUN_RELEASE, 3'd7, '0);
      push_item(OP_IDLE_ENTRY, 3'd0, '0);
      push_item(OP_SPARE_FIRST, 3'd7, TICKS_MAX);

      // Sleep resolution around the default and the tick threshold.
      configure(3'd5, 3'd2, 32'd100);
      push_item(OP_SLEEP_REQUEST, 3'd7, '0);
      push_item(OP_SLEEP_REQUEST, 3'd3, '0);
      push_item(OP_IDLE_ENTRY, 3'd0, TICKS_MAX);
      push_item(OP_IDLE_ENTRY, 3'd0, 32'd100);
      push_item(OP_IDLE_ENTRY, 3'd0, 32'd101);
      push_item(OP_SLEEP_REQUEST, 3'd1, '0);
      push_item(OP_IDLE_ENTRY, 3'd0, TICKS_MAX);
      push_item(OP_SLEEP_REQUEST, 3'd0, '0);
      push_item(OP_SLEEP_RELEASE, 3'd0, '0);
      push_item(OP_SLEEP_RELEASE, 3'd1, '0);
      push_item(OP_SLEEP_RELEASE, 3'd3, '0);
      push_item(OP_SLEEP_RELEASE, 3'd7, '0);

      // Run switching on request, no switch below the default, follow-up at idle.
      push_item(OP_RUN_REQUEST, 3'd5, '0);
      push_item(OP_RUN_REQUEST, 3'd7, '0);
      push_item(OP_RUN_REQUEST, 3'd1, '0);
      push_item(OP_RUN_RELEASE, 3'd7, '0);
      push_item(OP_IDLE_ENTRY, 3'd0, '0);
      push_item(OP_RUN_RELEASE, 3'd5, '0);
      push_item(OP_IDLE_ENTRY, 3'd0, TICKS_MAX);
      push_item(OP_SPARE_FIRST + 3'd1, 3'd2, '0);
      push_item(OP_SPARE_LAST, 3'd5, TICKS_MAX);

      // A run request that resolves to the lock mode does not switch.
      configure(3'd0, 3'd0, '0);
      push_item(OP_RUN_REQUEST, 3'd0, '0);
      push_item(OP_IDLE_ENTRY, 3'd0, TICKS_MAX);
      push_item(OP_RUN_RELEASE, 3'd0, '0);

      // Random traffic, light sender gaps.
      configure(3'd7, 3'd0, $urandom());
      random_phase(PHASE_ITEMS);

      // Random traffic, heavy sender gaps.
      sender_gap_pct = 66;
      configure(mode_type'($urandom_range(6, 2)), 3'd7, TICKS_MAX);
      random_phase(PHASE_ITEMS);

      // Back-to-back requests into a saturated counter.
      sender_gap_pct = 0;
      configure(mode_type'($urandom), mode_type'($urandom_range(6)), '0);
      saturation_phase();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Requests accepted %0d, results checked %0d, mismatches %0d.",
               accepted_count, checked_count, error_count);
      $display("Counter full %0d times, empty %0d times, deep sleep %0d, run switches %0d.",
               full_seen, empty_seen, deep_seen, switch_seen);
      if (error_count == 0) begin
         $display("power_mode_vote_arbiter_core_test: done, clean");
      end else begin
         $display("power_mode_vote_arbiter_core_test: done, errors");
      end
      $finish;
   end

endmodule
